>>> design/text_console_writer_unit_defines.svh
// ----------------------------------------------------------------------------
// text console writer assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define TCW_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tcw assertion failed");
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcw assertion failed");
`else
`define TCW_ASSERT(lbl, clk, rst_n, prop)
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// shared types and constants of the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int OP_W    = 2;
    localparam int COL_O_W = 7;
    localparam int ROW_O_W = 5;
    localparam int BYTE_W  = 8;
    localparam int CELL_W  = 16;

    localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [BYTE_W-1:0] SPACE_CODE   = 8'd32;
    localparam logic [BYTE_W-1:0] ATTR_RESET   = 8'd15;

    localparam logic CFG_DEFAULT_ATTR = 1'b0;
    localparam logic CFG_CLEAR_ATTR   = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_PUT        = 2'd0,
        OP_CLEAR      = 2'd1,
        OP_READ       = 2'd2,
        OP_SET_CURSOR = 2'd3
    } tcw_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_CLEAR,
        ST_RESP
    } tcw_state_t;

    typedef struct packed {
        logic [COL_O_W-1:0] cursor_col;
        logic [ROW_O_W-1:0] cursor_row;
        logic [BYTE_W-1:0]  cell_char;
        logic [BYTE_W-1:0]  cell_attr;
        logic               scrolled;
    } tcw_result_t;

endpackage

>>> design/text_console_writer_unit.sv
// one operation at a time: a new input transfer is accepted only in idle, once the
// result of the previous one has been handed to the output register
// scroll and clear sweep one cell per cycle
// reset: cursor, row base and handshake state cleared, attribute registers set to ATTR_RESET;
// cell memory not cleared, contents undefined until a clear or put writes them
// ----------------------------------------------------------------------------
// text_console_writer_unit
// text console engine with a rotating-row cell memory and cursor
// ----------------------------------------------------------------------------
module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [BYTE_W-1:0]   cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [OP_W-1:0]     opcode,
    input  logic [BYTE_W-1:0]   char_code,
    input  logic [BYTE_W-1:0]   attr,
    input  logic [COL_O_W-1:0]  col,
    input  logic [ROW_O_W-1:0]  row,
    input  logic                use_position,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [COL_O_W-1:0]  cursor_col,
    output logic [ROW_O_W-1:0]  cursor_row,
    output logic [BYTE_W-1:0]   cell_char,
    output logic [BYTE_W-1:0]   cell_attr,
    output logic                scrolled
);

    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    logic [BYTE_W-1:0] default_attr_reg, default_attr_next;
    logic [BYTE_W-1:0] clear_attr_reg, clear_attr_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;
    logic              out_free;
    logic              push;
    tcw_result_t       res;

    always_comb
    begin
        default_attr_next = default_attr_reg;
        clear_attr_next   = clear_attr_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEFAULT_ATTR: default_attr_next = cfg_wdata;
                CFG_CLEAR_ATTR:   clear_attr_next   = cfg_wdata;
                default:          default_attr_next = default_attr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_attr_reg <= ATTR_RESET;
            clear_attr_reg   <= ATTR_RESET;
        end
        else
        begin
            default_attr_reg <= default_attr_next;
            clear_attr_reg   <= clear_attr_next;
        end
    end

    tcw_ctrl #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .char_code    (char_code),
        .attr         (attr),
        .col          (col),
        .row          (row),
        .use_position (use_position),
        .default_attr (default_attr_reg),
        .clear_attr   (clear_attr_reg),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .out_free     (out_free),
        .push         (push),
        .res          (res)
    );

    tcw_cell_ram #(
        .DEPTH (CELLS),
        .WIDTH (CELL_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tcw_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .res        (res),
        .free       (out_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row),
        .cell_char  (cell_char),
        .cell_attr  (cell_attr),
        .scrolled   (scrolled)
    );

endmodule

>>> design/tcw_cell_ram.sv
// ----------------------------------------------------------------------------
// tcw_cell_ram
// single write port, single read port cell memory with registered read data
// ----------------------------------------------------------------------------
module tcw_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/tcw_out_reg.sv
// ----------------------------------------------------------------------------
// tcw_out_reg
// output register holding one result until its transfer completes
// ----------------------------------------------------------------------------
module tcw_out_reg
    import tcw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tcw_result_t         res,
    output logic                free,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [COL_O_W-1:0]  cursor_col,
    output logic [ROW_O_W-1:0]  cursor_row,
    output logic [BYTE_W-1:0]   cell_char,
    output logic [BYTE_W-1:0]   cell_attr,
    output logic                scrolled
);

    logic        valid_reg;
    logic        valid_next;
    tcw_result_t data_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push && free)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && free)
        begin
            data_reg <= res;
        end
    end

    assign out_valid  = valid_reg;
    assign cursor_col = data_reg.cursor_col;
    assign cursor_row = data_reg.cursor_row;
    assign cell_char  = data_reg.cell_char;
    assign cell_attr  = data_reg.cell_attr;
    assign scrolled   = data_reg.scrolled;

endmodule

>>> design/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// operation sequencer: cursor, row rotation base, memory access and sweeps
// ----------------------------------------------------------------------------
`include "text_console_writer_unit_defines.svh"

module tcw_ctrl
    import tcw_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [OP_W-1:0]                     opcode,
    input  logic [BYTE_W-1:0]                   char_code,
    input  logic [BYTE_W-1:0]                   attr,
    input  logic [COL_O_W-1:0]                  col,
    input  logic [ROW_O_W-1:0]                  row,
    input  logic                                use_position,
    input  logic [BYTE_W-1:0]                   default_attr,
    input  logic [BYTE_W-1:0]                   clear_attr,
    output logic                                ram_we,
    output logic [$clog2(COLS*ROWS)-1:0]        ram_waddr,
    output logic [CELL_W-1:0]                   ram_wdata,
    output logic                                ram_re,
    output logic [$clog2(COLS*ROWS)-1:0]        ram_raddr,
    input  logic [CELL_W-1:0]                   ram_rdata,
    input  logic                                out_free,
    output logic                                push,
    output tcw_result_t                         res
);

    localparam int CELLS  = COLS * ROWS;
    localparam int COL_W  = $clog2(COLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);

    tcw_state_t        state_reg, state_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [ROW_W-1:0]  base_reg, base_next;
    logic [ADDR_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic [ADDR_W-1:0] sweep_end_reg, sweep_end_next;
    tcw_result_t       res_reg, res_next;

    tcw_op_t           op;
    logic              in_fire;
    logic [COL_W-1:0]  col_c;
    logic [ROW_W-1:0]  row_c;
    logic [COL_W-1:0]  acc_col;
    logic [ROW_W-1:0]  acc_row;
    logic [ROW_W:0]    row_sum;
    logic [ROW_W-1:0]  prow;
    logic [ADDR_W-1:0] acc_addr;
    logic [ADDR_W-1:0] base_addr;
    logic              is_newline;
    logic              wrap;
    logic              scroll_hit;
    logic [COL_W-1:0]  put_col;
    logic [ROW_W-1:0]  put_row;
    logic [BYTE_W-1:0] attr_eff;

    assign op       = tcw_op_t'(opcode);
    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    // clamp positions beyond the screen to the last column or row
    assign col_c = (32'(col) >= COLS) ? COL_W'(COLS - 1) : COL_W'(col);
    assign row_c = (32'(row) >= ROWS) ? ROW_W'(ROWS - 1) : ROW_W'(row);

    assign acc_col = (op == OP_PUT && !use_position) ? cur_col_reg : col_c;
    assign acc_row = (op == OP_PUT && !use_position) ? cur_row_reg : row_c;

    // logical row to physical row through the rotation base
    assign row_sum  = {1'b0, acc_row} + {1'b0, base_reg};
    assign prow     = (32'(row_sum) >= ROWS) ? ROW_W'(row_sum - (ROW_W + 1)'(ROWS))
                                             : ROW_W'(row_sum);
    assign acc_addr = ADDR_W'(ADDR_W'(prow) * ADDR_W'(COLS)) + ADDR_W'(acc_col);
    assign base_addr = ADDR_W'(ADDR_W'(base_reg) * ADDR_W'(COLS));

    assign is_newline = (char_code == NEWLINE_CODE);
    assign wrap       = is_newline || (acc_col == COL_W'(COLS - 1));
    assign scroll_hit = wrap && (acc_row == ROW_W'(ROWS - 1));
    assign attr_eff   = (attr == '0) ? default_attr : attr;

    always_comb
    begin
        put_col = acc_col + 1'b1;
        put_row = acc_row;
        if (wrap)
        begin
            put_col = '0;
            put_row = scroll_hit ? acc_row : acc_row + 1'b1;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        base_next       = base_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_end_next  = sweep_end_reg;
        res_next        = res_reg;
        ram_we          = 1'b0;
        ram_waddr       = acc_addr;
        ram_wdata       = {attr_eff, char_code};
        ram_re          = 1'b0;
        ram_raddr       = acc_addr;
        push            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    res_next.cell_char = '0;
                    res_next.cell_attr = '0;
                    res_next.scrolled  = 1'b0;
                    state_next         = ST_RESP;
                    unique case (op)
                        OP_PUT:
                        begin
                            ram_we       = !is_newline;
                            cur_col_next = put_col;
                            cur_row_next = put_row;
                            if (scroll_hit)
                            begin
                                // old top row becomes the blank bottom row
                                res_next.scrolled = 1'b1;
                                base_next         = (base_reg == ROW_W'(ROWS - 1))
                                                    ? '0 : base_reg + 1'b1;
                                sweep_addr_next   = base_addr;
                                sweep_end_next    = base_addr + ADDR_W'(COLS - 1);
                                state_next        = ST_SCROLL;
                            end
                        end
                        OP_CLEAR:
                        begin
                            cur_col_next    = '0;
                            cur_row_next    = '0;
                            base_next       = '0;
                            sweep_addr_next = '0;
                            sweep_end_next  = ADDR_W'(CELLS - 1);
                            state_next      = ST_CLEAR;
                        end
                        OP_READ:
                        begin
                            ram_re     = 1'b1;
                            state_next = ST_READ;
                        end
                        OP_SET_CURSOR:
                        begin
                            cur_col_next = col_c;
                            cur_row_next = row_c;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res_next.cell_char = ram_rdata[BYTE_W-1:0];
                res_next.cell_attr = ram_rdata[CELL_W-1:BYTE_W];
                state_next         = ST_RESP;
            end
            ST_SCROLL, ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_addr_reg;
                ram_wdata = (state_reg == ST_CLEAR) ? {clear_attr, SPACE_CODE} : '0;
                if (sweep_addr_reg == sweep_end_reg)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + 1'b1;
                end
            end
            ST_RESP:
            begin
                push = 1'b1;
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res_next.cursor_col = COL_O_W'(cur_col_next);
        res_next.cursor_row = ROW_O_W'(cur_row_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            base_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            base_reg    <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sweep_addr_reg <= sweep_addr_next;
        sweep_end_reg  <= sweep_end_next;
        res_reg        <= res_next;
    end

    assign res = res_reg;

    `TCW_ASSERT(a_sweep_writes, clk, rst_n, (state_reg == ST_SCROLL || state_reg == ST_CLEAR) |-> ram_we)
    `TCW_ASSERT_NEXT(a_scroll_start, clk, rst_n, in_fire && op == OP_PUT && scroll_hit, state_reg == ST_SCROLL)
    `TCW_ASSERT_NEXT(a_resp_hold, clk, rst_n, state_reg == ST_RESP && !out_free, state_reg == ST_RESP && $stable(res_reg))
    `TCW_ASSERT(a_pos_range, clk, rst_n, 32'(cur_col_reg) < COLS && 32'(cur_row_reg) < ROWS && 32'(base_reg) < ROWS)

endmodule

>>> tb/tb_text_console_writer_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_console_writer_unit
// Self-checking bench for the text console writer. A scoreboard keeps its own
// copy of the screen, cursor and attribute registers. It predicts the cursor,
// the cell read and the scroll flag for every input transfer, and checks each
// output transfer against the oldest prediction. Stimulus is a directed pass
// over the corner cases. It is followed by random text runs, positioned puts,
// reads, cursor moves and clears under several attribute settings. Sender
// bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
import tcw_pkg::*;

class console_scoreboard;
    localparam int NCOLS  = 80;
    localparam int NROWS  = 25;
    localparam int NCELLS = NCOLS * NROWS;

    logic [CELL_W-1:0] screen [NCELLS];
    bit                written [NCELLS];
    int unsigned       cursor;
    logic [BYTE_W-1:0] dflt_attr;
    logic [BYTE_W-1:0] clr_attr;
    tcw_result_t       awaited_results [$];
    int unsigned       failures;

    function new();
        foreach (screen[i])
        begin
            screen[i]  = '0;
            written[i] = 1'b0;
        end
        cursor    = 0;
        dflt_attr = ATTR_RESET;
        clr_attr  = ATTR_RESET;
        failures  = 0;
    endfunction

    function int unsigned clamp_index(logic [COL_O_W-1:0] c, logic [ROW_O_W-1:0] r);
        int unsigned cc;
        int unsigned rr;
        cc = (c >= NCOLS) ? NCOLS - 1 : c;
        rr = (r >= NROWS) ? NROWS - 1 : r;
        return rr * NCOLS + cc;
    endfunction

    function bit cell_defined(logic [COL_O_W-1:0] c, logic [ROW_O_W-1:0] r);
        return written[clamp_index(c, r)];
    endfunction

    function void set_register(logic idx, logic [BYTE_W-1:0] val);
        if (idx == CFG_DEFAULT_ATTR)
            dflt_attr = val;
        else
            clr_attr = val;
    endfunction

    function int unsigned pending();
        return awaited_results.size();
    endfunction

    function void note_transfer(tcw_op_t op, logic [BYTE_W-1:0] ch, logic [BYTE_W-1:0] at,
                                logic [COL_O_W-1:0] c, logic [ROW_O_W-1:0] r, logic up);
        tcw_result_t res;
        int unsigned pos;
        logic [CELL_W-1:0] entry;
        res = '0;
        case (op)
            OP_PUT:
            begin
                pos = up ? clamp_index(c, r) : cursor;
                if (ch == NEWLINE_CODE)
                    pos = (pos / NCOLS) * NCOLS + (NCOLS - 1);
                else
                begin
                    if (at == 0)
                        at = dflt_attr;
                    screen[pos]  = {at, ch};
                    written[pos] = 1'b1;
                end
                pos++;
                if (pos >= NCELLS)
                begin
                    // rows move up, the new bottom row is zeroed
                    for (int i = 0; i < NCELLS - NCOLS; i++)
                    begin
                        screen[i]  = screen[i + NCOLS];
                        written[i] = written[i + NCOLS];
                    end
                    for (int i = NCELLS - NCOLS; i < NCELLS; i++)
                    begin
                        screen[i]  = '0;
                        written[i] = 1'b1;
                    end
                    pos -= NCOLS;
                    res.scrolled = 1'b1;
                end
                cursor = pos;
            end
            OP_CLEAR:
            begin
                foreach (screen[i])
                begin
                    screen[i]  = {clr_attr, SPACE_CODE};
                    written[i] = 1'b1;
                end
                cursor = 0;
            end
            OP_READ:
            begin
                entry = screen[clamp_index(c, r)];
                res.cell_char = entry[BYTE_W-1:0];
                res.cell_attr = entry[CELL_W-1:BYTE_W];
            end
            default:
                cursor = clamp_index(c, r);
        endcase
        res.cursor_col = COL_O_W'(cursor % NCOLS);
        res.cursor_row = ROW_O_W'(cursor / NCOLS);
        awaited_results.push_back(res);
    endfunction

    function void complain(string what, int unsigned exp_val, int unsigned act_val);
        failures++;
        if (failures <= 10)
            $display("[%0t] %s: expected %0d, actual %0d", $time, what, exp_val, act_val);
    endfunction

    function void check_transfer(tcw_result_t act);
        tcw_result_t exp;
        if (awaited_results.size() == 0)
        begin
            complain("output transfer with nothing pending", 0, 1);
            return;
        end
        exp = awaited_results.pop_front();
        if (act.cursor_col !== exp.cursor_col)
            complain("cursor_col", exp.cursor_col, act.cursor_col);
        if (act.cursor_row !== exp.cursor_row)
            complain("cursor_row", exp.cursor_row, act.cursor_row);
        if (act.cell_char !== exp.cell_char)
            complain("cell_char", exp.cell_char, act.cell_char);
        if (act.cell_attr !== exp.cell_attr)
            complain("cell_attr", exp.cell_attr, act.cell_attr);
        if (act.scrolled !== exp.scrolled)
            complain("scrolled", exp.scrolled, act.scrolled);
    endfunction

    function void account_leftover();
        if (awaited_results.size() != 0)
            complain("results never seen", 0, awaited_results.size());
    endfunction
endclass

module tb_text_console_writer_unit;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                cfg_we       = 1'b0;
    logic                cfg_index    = 1'b0;
    logic [BYTE_W-1:0]   cfg_wdata    = '0;
    logic                in_valid     = 1'b0;
    logic                in_ready;
    logic [OP_W-1:0]     opcode       = '0;
    logic [BYTE_W-1:0]   char_code    = '0;
    logic [BYTE_W-1:0]   attr         = '0;
    logic [COL_O_W-1:0]  col          = '0;
    logic [ROW_O_W-1:0]  row          = '0;
    logic                use_position = 1'b0;
    logic                out_valid;
    logic                out_ready    = 1'b0;
    logic [COL_O_W-1:0]  cursor_col;
    logic [ROW_O_W-1:0]  cursor_row;
    logic [BYTE_W-1:0]   cell_char;
    logic [BYTE_W-1:0]   cell_attr;
    logic                scrolled;

    console_scoreboard sb;
    int burst_left = 0;
    int items_sent = 0;
    int rx_cycle   = 0;
    int rx_stall   = 0;

    text_console_writer_unit dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_transfer(tcw_result_t'({cursor_col, cursor_row, cell_char,
                                                 cell_attr, scrolled}));
            if (in_valid && in_ready)
                sb.note_transfer(tcw_op_t'(opcode), char_code, attr, col, row, use_position);
        end
    end

    // receiver: steady windows, then random stalls
    always @(negedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 600 < 150)
            out_ready = 1'b1;
        else if (rx_stall > 0)
        begin
            out_ready = 1'b0;
            rx_stall--;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            out_ready = 1'b0;
            rx_stall  = $urandom_range(0, 7);
        end
        else
            out_ready = 1'b1;
    end

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [BYTE_W-1:0] rand_char();
        if ($urandom_range(0, 9) == 0)
            return NEWLINE_CODE;
        return rand_byte();
    endfunction

    function automatic logic [BYTE_W-1:0] rand_attr();
        if ($urandom_range(0, 3) == 0)
            return '0;
        return rand_byte();
    endfunction

    function automatic logic [COL_O_W-1:0] rand_col();
        return COL_O_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                    : $urandom_range(0, 79));
    endfunction

    function automatic logic [ROW_O_W-1:0] rand_row();
        return ROW_O_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                    : $urandom_range(0, 24));
    endfunction

    function automatic logic [COL_O_W-1:0] any_col();
        return COL_O_W'($urandom_range(0, 127));
    endfunction

    function automatic logic [ROW_O_W-1:0] any_row();
        return ROW_O_W'($urandom_range(0, 31));
    endfunction

    task automatic pace();
        if (burst_left == 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
    endtask

    task automatic send_item(tcw_op_t op, logic [BYTE_W-1:0] ch, logic [BYTE_W-1:0] at,
                             logic [COL_O_W-1:0] c, logic [ROW_O_W-1:0] r, logic up);
        pace();
        @(negedge clk);
        // never read a cell that was not written yet, put there instead
        if (op == OP_READ && !sb.cell_defined(c, r))
        begin
            op = OP_PUT;
            up = 1'b1;
        end
        in_valid     = 1'b1;
        opcode       = op;
        char_code    = ch;
        attr         = at;
        col          = c;
        row          = r;
        use_position = up;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_config(logic idx, logic [BYTE_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.set_register(idx, val);
    endtask

    task automatic random_sequence();
        int kind;
        int n;
        tcw_op_t op;
        kind = $urandom_range(0, 99);
        if (kind < 55)
        begin
            // text run at the cursor, often near the bottom
            if ($urandom_range(0, 2) == 0)
                send_item(OP_SET_CURSOR, rand_byte(), rand_byte(),
                          rand_col(), ROW_O_W'($urandom_range(20, 31)), rand_bit());
            n = $urandom_range(5, 40);
            repeat (n)
                send_item(OP_PUT, rand_char(), rand_attr(), rand_col(), rand_row(), 1'b0);
        end
        else if (kind < 70)
        begin
            n = $urandom_range(1, 5);
            repeat (n)
                send_item(OP_PUT, rand_char(), rand_attr(), rand_col(), rand_row(), 1'b1);
        end
        else if (kind < 85)
        begin
            n = $urandom_range(1, 6);
            repeat (n)
                send_item(OP_READ, rand_byte(), rand_byte(),
                          rand_col(), rand_row(), rand_bit());
        end
        else if (kind < 94)
            send_item(OP_SET_CURSOR, rand_byte(), rand_byte(),
                      rand_col(), rand_row(), rand_bit());
        else if (kind < 97)
            send_item(OP_CLEAR, rand_byte(), rand_byte(), any_col(), any_row(), rand_bit());
        else
        begin
            op = tcw_op_t'(OP_W'($urandom_range(0, 3)));
            if (op == OP_CLEAR)
                op = OP_READ;
            send_item(op, rand_byte(), rand_byte(), any_col(), any_row(), rand_bit());
        end
    endtask

    initial
    begin
        logic [BYTE_W-1:0] dflt_plan [4];
        logic [BYTE_W-1:0] clr_plan [4];
        int target;
        int guard;
        sb = new();
        dflt_plan = '{8'd0, 8'd255, 8'd0, 8'd15};
        clr_plan  = '{8'd255, 8'd0, 8'd0, 8'd15};
        dflt_plan[2] = BYTE_W'($urandom_range(1, 254));
        clr_plan[2]  = BYTE_W'($urandom_range(1, 254));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_config(CFG_DEFAULT_ATTR, 8'h4e);
        write_config(CFG_CLEAR_ATTR, 8'h17);

        // directed corner cases
        send_item(OP_PUT, 8'h41, 8'h00, 7'd0, 5'd0, 1'b0);
        send_item(OP_READ, 8'h00, 8'h00, 7'd0, 5'd0, 1'b0);
        send_item(OP_CLEAR, 8'hff, 8'hff, 7'd127, 5'd31, 1'b1);
        send_item(OP_READ, 8'h00, 8'h00, 7'd0, 5'd0, 1'b0);
        send_item(OP_PUT, 8'hff, 8'hff, 7'd127, 5'd31, 1'b1);
        send_item(OP_READ, 8'h00, 8'h00, 7'd127, 5'd31, 1'b0);
        send_item(OP_READ, 8'h00, 8'h00, 7'd79, 5'd23, 1'b0);
        send_item(OP_SET_CURSOR, 8'h00, 8'h00, 7'd79, 5'd24, 1'b0);
        send_item(OP_PUT, NEWLINE_CODE, 8'h00, 7'd0, 5'd0, 1'b0);
        send_item(OP_PUT, NEWLINE_CODE, 8'h22, 7'd5, 5'd24, 1'b1);
        send_item(OP_PUT, NEWLINE_CODE, 8'h00, 7'd40, 5'd3, 1'b1);
        send_item(OP_PUT, 8'h00, 8'h80, 7'd0, 5'd0, 1'b0);
        send_item(OP_SET_CURSOR, 8'h00, 8'h00, 7'd100, 5'd2, 1'b0);
        send_item(OP_PUT, 8'h7e, 8'h01, 7'd0, 5'd0, 1'b0);
        send_item(OP_PUT, 8'h30, 8'h00, 7'd5, 5'd30, 1'b1);
        send_item(OP_READ, 8'h00, 8'h00, 7'd5, 5'd30, 1'b0);
        send_item(OP_READ, 8'hff, 8'hff, 7'd64, 5'd16, 1'b1);
        send_item(OP_SET_CURSOR, 8'h00, 8'h00, 7'd0, 5'd0, 1'b1);
        send_item(OP_PUT, 8'h78, 8'h00, 7'd99, 5'd19, 1'b0);
        send_item(OP_READ, 8'h00, 8'h00, 7'd0, 5'd0, 1'b0);
        send_item(OP_SET_CURSOR, 8'h00, 8'h00, 7'd127, 5'd31, 1'b0);
        send_item(OP_PUT, 8'h80, 8'h7f, 7'd0, 5'd0, 1'b0);

        // random phases, each under its own attribute settings
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_drained();
            write_config(CFG_DEFAULT_ATTR, dflt_plan[phase]);
            write_config(CFG_CLEAR_ATTR, clr_plan[phase]);
            target = items_sent + 400;
            while (items_sent < target)
                random_sequence();
        end

        @(negedge clk);
        in_valid = 1'b0;
        for (guard = 0; guard < 5000 && sb.pending() != 0; guard++)
            @(posedge clk);
        repeat (100) @(posedge clk);
        sb.account_leftover();
        if (sb.failures == 0)
            $display("[text_console_writer_unit] OK");
        else
            $display("[text_console_writer_unit] ERROR");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("[text_console_writer_unit] ERROR");
        $finish;
    end

endmodule
